// ===== src/cau_pkg.sv =====
// Shared types and codes for the complex arithmetic unit.
`default_nettype none
package cau_pkg;

	typedef enum logic [1:0] {
		KIND_ADD = 2'd0,
		KIND_SUB = 2'd1,
		KIND_MUL = 2'd2,
		KIND_DIV = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK  = 2'd0,
		ST_SAT = 2'd1,
		ST_DZ  = 2'd2,
		ST_RSV = 2'd3
	} status_t;

	// control that rides along with each beat through the divider row
	typedef struct packed {
		logic is_div;
		logic dz;
		logic neg_re;
		logic neg_im;
	} ctl_t;

endpackage
`default_nettype wire

// ===== src/cau_front.sv =====
// Front end: products, sums, sign/magnitude and divider operand set-up.
`default_nettype none
module cau_front #(
	parameter int W  = 32,
	parameter int F  = 16,
	parameter int NW = 2 * W + F + 2,
	parameter int DW = 2 * W + 1
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire cau_pkg::kind_t       kind,
	input  wire logic signed [W-1:0]  a_re,
	input  wire logic signed [W-1:0]  a_im,
	input  wire logic signed [W-1:0]  b_re,
	input  wire logic signed [W-1:0]  b_im,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output cau_pkg::ctl_t             out_ctl,
	output logic [NW-1:0]             out_rem_re,
	output logic [NW-1:0]             out_rem_im,
	output logic [DW-1:0]             out_den,
	output logic [W:0]                out_q_re,
	output logic [W:0]                out_q_im
);
	import cau_pkg::*;

	localparam logic [2*W:0] HALF = (F > 0) ? ((2*W+1)'(1) << (F - 1)) : '0;
	localparam logic [2*W:0] QMAX = (2*W+1)'(1) << W;

	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy1, rdy2, rdy3, rdy4;

	kind_t kind_s1, kind_s2, kind_s3;
	logic signed [W:0]     sum_re_s1, sum_im_s1;
	logic signed [2*W-1:0] p_rr_s1, p_ii_s1, p_ri_s1, p_ir_s1, p_cc_s1, p_dd_s1;
	logic signed [2*W:0]   val_re_s2, val_im_s2;
	logic [2*W-1:0]        den_s2, den_s3;
	logic [2*W-1:0]        mag_re_s3, mag_im_s3;
	logic                  neg_re_s3, neg_im_s3, dz_s3;
	logic [2*W:0]          r_re, r_im;

	assign rdy4     = !v_s4 || out_ready;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;
	assign out_valid = v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	// stage 1: all products, plus the add/sub result
	always_ff @(posedge clk) begin
		if (rdy1) begin
			kind_s1 <= kind;
			if (kind == KIND_SUB) begin
				sum_re_s1 <= (W+1)'(a_re) - (W+1)'(b_re);
				sum_im_s1 <= (W+1)'(a_im) - (W+1)'(b_im);
			end else begin
				sum_re_s1 <= (W+1)'(a_re) + (W+1)'(b_re);
				sum_im_s1 <= (W+1)'(a_im) + (W+1)'(b_im);
			end
			p_rr_s1 <= (2*W)'(a_re) * (2*W)'(b_re);
			p_ii_s1 <= (2*W)'(a_im) * (2*W)'(b_im);
			p_ri_s1 <= (2*W)'(a_re) * (2*W)'(b_im);
			p_ir_s1 <= (2*W)'(a_im) * (2*W)'(b_re);
			p_cc_s1 <= (2*W)'(b_re) * (2*W)'(b_re);
			p_dd_s1 <= (2*W)'(b_im) * (2*W)'(b_im);
		end
	end

	// stage 2: combine products per operation
	always_ff @(posedge clk) begin
		if (rdy2) begin
			kind_s2 <= kind_s1;
			den_s2  <= (2*W)'($unsigned(p_cc_s1)) + (2*W)'($unsigned(p_dd_s1));
			case (kind_s1)
				KIND_MUL: begin
					val_re_s2 <= (2*W+1)'(p_rr_s1) - (2*W+1)'(p_ii_s1);
					val_im_s2 <= (2*W+1)'(p_ri_s1) + (2*W+1)'(p_ir_s1);
				end
				KIND_DIV: begin
					val_re_s2 <= (2*W+1)'(p_rr_s1) + (2*W+1)'(p_ii_s1);
					val_im_s2 <= (2*W+1)'(p_ir_s1) - (2*W+1)'(p_ri_s1);
				end
				default: begin
					val_re_s2 <= (2*W+1)'(sum_re_s1);
					val_im_s2 <= (2*W+1)'(sum_im_s1);
				end
			endcase
		end
	end

	// stage 3: sign and magnitude
	always_ff @(posedge clk) begin
		if (rdy3) begin
			kind_s3   <= kind_s2;
			den_s3    <= den_s2;
			dz_s3     <= (kind_s2 == KIND_DIV) && (den_s2 == '0);
			neg_re_s3 <= val_re_s2[2*W];
			neg_im_s3 <= val_im_s2[2*W];
			mag_re_s3 <= (2*W)'(val_re_s2[2*W] ? -val_re_s2 : val_re_s2);
			mag_im_s3 <= (2*W)'(val_im_s2[2*W] ? -val_im_s2 : val_im_s2);
		end
	end

	// non-divide result magnitude, rounded for multiply
	always_comb begin
		if (kind_s3 == KIND_MUL) begin
			r_re = ((2*W+1)'(mag_re_s3) + HALF) >> F;
			r_im = ((2*W+1)'(mag_im_s3) + HALF) >> F;
		end else begin
			r_re = (2*W+1)'(mag_re_s3);
			r_im = (2*W+1)'(mag_im_s3);
		end
	end

	// stage 4: divider operands, or the finished magnitude clipped to W+1 bits
	always_ff @(posedge clk) begin
		if (rdy4) begin
			out_ctl.is_div <= (kind_s3 == KIND_DIV);
			out_ctl.dz     <= dz_s3;
			out_ctl.neg_re <= neg_re_s3;
			out_ctl.neg_im <= neg_im_s3;
			out_den        <= {den_s3, 1'b0};
			out_rem_re     <= (NW'(mag_re_s3) << (F + 1)) + NW'(den_s3);
			out_rem_im     <= (NW'(mag_im_s3) << (F + 1)) + NW'(den_s3);
			if (kind_s3 == KIND_DIV) begin
				out_q_re <= '0;
				out_q_im <= '0;
			end else begin
				out_q_re <= (r_re >= QMAX) ? QMAX[W:0] : r_re[W:0];
				out_q_im <= (r_im >= QMAX) ? QMAX[W:0] : r_im[W:0];
			end
		end
	end

endmodule
`default_nettype wire

// ===== src/cau_cell.sv =====
// One restoring-division cell: resolves one quotient bit for both parts.
`default_nettype none
module cau_cell #(
	parameter int W     = 32,
	parameter int NW    = 82,
	parameter int DW    = 65,
	parameter int SHIFT = 0
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire cau_pkg::ctl_t  in_ctl,
	input  wire logic [NW-1:0]  in_rem_re,
	input  wire logic [NW-1:0]  in_rem_im,
	input  wire logic [DW-1:0]  in_den,
	input  wire logic [W:0]     in_q_re,
	input  wire logic [W:0]     in_q_im,
	output logic                out_valid,
	input  wire logic           out_ready,
	output cau_pkg::ctl_t       out_ctl,
	output logic [NW-1:0]       out_rem_re,
	output logic [NW-1:0]       out_rem_im,
	output logic [DW-1:0]       out_den,
	output logic [W:0]          out_q_re,
	output logic [W:0]          out_q_im
);
	import cau_pkg::*;

	localparam int CW = (NW > DW + SHIFT) ? NW : DW + SHIFT;
	localparam logic [W:0] QBIT = (W+1)'(1) << SHIFT;

	logic [CW-1:0] dsh, dif_re, dif_im;
	logic          ge_re, ge_im;

	assign in_ready = !out_valid || out_ready;
	assign dsh      = CW'(in_den) << SHIFT;
	assign dif_re   = CW'(in_rem_re) - dsh;
	assign dif_im   = CW'(in_rem_im) - dsh;
	assign ge_re    = in_ctl.is_div && (CW'(in_rem_re) >= dsh);
	assign ge_im    = in_ctl.is_div && (CW'(in_rem_im) >= dsh);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (in_ready) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			out_ctl    <= in_ctl;
			out_den    <= in_den;
			out_rem_re <= ge_re ? NW'(dif_re) : in_rem_re;
			out_rem_im <= ge_im ? NW'(dif_im) : in_rem_im;
			out_q_re   <= ge_re ? (in_q_re | QBIT) : in_q_re;
			out_q_im   <= ge_im ? (in_q_im | QBIT) : in_q_im;
		end
	end

endmodule
`default_nettype wire

// ===== src/complex_arithmetic_unit_top.sv =====
// Complex add/sub/mul/div unit, signed fixed point, saturating.
// Pipeline: four front stages, DATA_WIDTH + 1 division cells, one output
//   register. Throughput: one beat per cycle unless m_tready stalls output;
//   every stage is its own register with its own ready, so bubbles close up
//   and input keeps flowing while a result waits, until the stages fill.
// Reset: arst_n clears the valid bits only; payload registers are not reset.
`default_nettype none
module complex_arithmetic_unit_top #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   s_tvalid,
	output logic                                        s_tready,
	// s_tdata, low bit up: a_re, a_im, b_re, b_im, zero pad to bytes
	input  wire logic [((4*DATA_WIDTH+7)/8)*8-1:0]      s_tdata,
	// s_tuser: kind
	input  wire logic [1:0]                             s_tuser,
	output logic                                        m_tvalid,
	input  wire logic                                   m_tready,
	// m_tdata, low bit up: res_re, res_im, zero pad to bytes
	output logic [((2*DATA_WIDTH+7)/8)*8-1:0]           m_tdata,
	// m_tuser: status
	output logic [1:0]                                  m_tuser
);
	import cau_pkg::*;

	localparam int W    = DATA_WIDTH;
	localparam int NW   = 2 * W + FRAC_BITS + 2;   // dividend/remainder width
	localparam int DW   = 2 * W + 1;               // doubled denominator width
	localparam int NC   = W + 1;                   // one cell per quotient bit
	localparam int MTDW = ((2*DATA_WIDTH+7)/8)*8;
	localparam logic [W:0] LIM_POS = ((W+1)'(1) << (W - 1)) - (W+1)'(1);
	localparam logic [W:0] LIM_NEG = (W+1)'(1) << (W - 1);

	// chain links: index 0 is the front end output, NC the last cell output
	logic          c_valid [NC+1];
	logic          c_ready [NC+1];
	ctl_t          c_ctl   [NC+1];
	logic [NW-1:0] c_rem_re[NC+1];
	logic [NW-1:0] c_rem_im[NC+1];
	logic [DW-1:0] c_den   [NC+1];
	logic [W:0]    c_q_re  [NC+1];
	logic [W:0]    c_q_im  [NC+1];

	cau_front #(.W(W), .F(FRAC_BITS), .NW(NW), .DW(DW)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.kind       (kind_t'(s_tuser)),
		.a_re       (s_tdata[W-1:0]),
		.a_im       (s_tdata[2*W-1:W]),
		.b_re       (s_tdata[3*W-1:2*W]),
		.b_im       (s_tdata[4*W-1:3*W]),
		.out_valid  (c_valid[0]),
		.out_ready  (c_ready[0]),
		.out_ctl    (c_ctl[0]),
		.out_rem_re (c_rem_re[0]),
		.out_rem_im (c_rem_im[0]),
		.out_den    (c_den[0]),
		.out_q_re   (c_q_re[0]),
		.out_q_im   (c_q_im[0])
	);

	// cell k settles quotient bit W-k; the top bit only flags saturation
	for (genvar k = 0; k < NC; k++) begin : g_cell
		cau_cell #(.W(W), .NW(NW), .DW(DW), .SHIFT(W - k)) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.in_valid   (c_valid[k]),
			.in_ready   (c_ready[k]),
			.in_ctl     (c_ctl[k]),
			.in_rem_re  (c_rem_re[k]),
			.in_rem_im  (c_rem_im[k]),
			.in_den     (c_den[k]),
			.in_q_re    (c_q_re[k]),
			.in_q_im    (c_q_im[k]),
			.out_valid  (c_valid[k+1]),
			.out_ready  (c_ready[k+1]),
			.out_ctl    (c_ctl[k+1]),
			.out_rem_re (c_rem_re[k+1]),
			.out_rem_im (c_rem_im[k+1]),
			.out_den    (c_den[k+1]),
			.out_q_re   (c_q_re[k+1]),
			.out_q_im   (c_q_im[k+1])
		);
	end

	// output stage: saturate, restore sign, pick status
	logic [W:0]   lim_re, lim_im, mag_re, mag_im;
	logic         sat_re, sat_im;
	logic [W-1:0] res_re_q, res_im_q;
	status_t      status_q;
	logic         out_valid_q;
	ctl_t         ctl_l;

	assign ctl_l   = c_ctl[NC];
	assign lim_re  = ctl_l.neg_re ? LIM_NEG : LIM_POS;
	assign lim_im  = ctl_l.neg_im ? LIM_NEG : LIM_POS;
	assign sat_re  = c_q_re[NC] > lim_re;
	assign sat_im  = c_q_im[NC] > lim_im;
	assign mag_re  = sat_re ? lim_re : c_q_re[NC];
	assign mag_im  = sat_im ? lim_im : c_q_im[NC];
	assign c_ready[NC] = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (c_ready[NC]) begin
			out_valid_q <= c_valid[NC];
		end
	end

	always_ff @(posedge clk) begin
		if (c_ready[NC]) begin
			if (ctl_l.dz) begin
				res_re_q <= '0;
				res_im_q <= '0;
				status_q <= ST_DZ;
			end else begin
				res_re_q <= W'(ctl_l.neg_re ? -mag_re : mag_re);
				res_im_q <= W'(ctl_l.neg_im ? -mag_im : mag_im);
				status_q <= (sat_re || sat_im) ? ST_SAT : ST_OK;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = MTDW'({res_im_q, res_re_q});
	assign m_tuser  = status_q;

	// divide by zero always delivers a zero result
	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && status_q == ST_DZ) |-> (res_re_q == '0 && res_im_q == '0))
		else $error("divide by zero beat carries non-zero data");

	// saturated status means at least one part sits at a limit
	a_sat_lim: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && status_q == ST_SAT) |->
		(res_re_q == W'(LIM_POS) || res_re_q == W'(LIM_NEG) ||
		 res_im_q == W'(LIM_POS) || res_im_q == W'(LIM_NEG)))
		else $error("saturation flagged without a limit value");

	// the reserved status code is never produced
	a_no_rsv: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (status_q != ST_RSV))
		else $error("reserved status code on output");

	// with the output stage empty the last cell must be able to move on
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> c_ready[NC])
		else $error("output stage empty yet chain stalled");

endmodule
`default_nettype wire
